[rtl/eaf_pkg.sv]
// Package for the eased alpha fade block: widths, register indexes, curve codes
// and the command/status structs that pass between controller and datapath.
// No dependencies.
package eaf_pkg;

	// elapsed-time accumulator width
	localparam int TIME_BITS = 16;
	localparam int WIDE_W    = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam int SUM_W     = WIDE_W + 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	// quotient bits of u = elapsed * 2^16 / duration
	localparam int U_BITS   = 16;
	localparam int CNT_BITS = $clog2(U_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(U_BITS - 1);

	typedef enum logic [1:0] {
		CFG_CURVE_MODE    = 2'd0,
		CFG_START_LEVEL   = 2'd1,
		CFG_END_LEVEL     = 2'd2,
		CFG_FADE_DURATION = 2'd3
	} eaf_cfg_idx_t;

	typedef enum logic [1:0] {
		CURVE_LINEAR   = 2'd0,
		CURVE_EASE_IN  = 2'd1,
		CURVE_EASE_OUT = 2'd2,
		CURVE_IN_OUT   = 2'd3
	} eaf_curve_t;

	typedef struct packed {
		logic accept;     // add tick to elapsed time
		logic check;      // latch done, load divider
		logic div_step;   // one quotient bit
		logic ease_mul;   // square u (or its complement)
		logic ease;       // form the eased value
		logic scale;      // eased value times level span
		logic result;     // load the output register
	} eaf_cmd_t;

	typedef struct packed {
		logic fade_over;  // done already, or elapsed reached duration
	} eaf_stat_t;

endpackage

[rtl/eaf_ctrl.sv]
// Controller state machine of the eased alpha fade block.
// Sequences accumulate, divide, ease and scale; owns the output valid.
// Depends on eaf_pkg.
module eaf_ctrl import eaf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tick_valid,
	output logic      tick_stall,
	output logic      result_valid,
	input  logic      result_stall,
	input  eaf_stat_t stat,
	output eaf_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EASE_MUL,
		ST_EASE,
		ST_SCALE,
		ST_RESULT
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                valid_q;
	logic                out_free;

	assign out_free     = !valid_q || !result_stall;
	assign tick_stall   = (state_q != ST_IDLE);
	assign result_valid = valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_IDLE) && tick_valid;
		cmd.check    = (state_q == ST_CHECK);
		cmd.div_step = (state_q == ST_DIV);
		cmd.ease_mul = (state_q == ST_EASE_MUL);
		cmd.ease     = (state_q == ST_EASE);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.result   = (state_q == ST_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.result)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (tick_valid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (stat.fade_over)
						state_q <= ST_RESULT;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_EASE_MUL;
				end
				ST_EASE_MUL: state_q <= ST_EASE;
				ST_EASE:     state_q <= ST_SCALE;
				ST_SCALE:    state_q <= ST_RESULT;
				ST_RESULT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/eaf_datapath.sv]
// Datapath of the eased alpha fade block: config registers, elapsed-time
// accumulator, restoring divider, shared 16x16 multiplier and output register.
// Depends on eaf_pkg.
module eaf_datapath import eaf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [15:0] tick_time,
	input  eaf_cmd_t    cmd,
	output eaf_stat_t   stat,
	output logic [7:0]  alpha_out,
	output logic        fade_done
);

	// config
	logic [1:0]  curve_mode_q;
	logic [7:0]  start_level_q;
	logic [7:0]  end_level_q;
	logic [15:0] fade_duration_q;

	// state
	logic [TIME_BITS-1:0] elapsed_q;
	logic                 done_q;

	// work registers
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [31:0] prod_q;
	logic [15:0] ease_q;
	logic [7:0]  alpha_q;
	logic        fade_done_q;

	logic [SUM_W-1:0]  sum;
	logic [WIDE_W-1:0] elapsed_wide;
	logic [WIDE_W-1:0] dur_wide;
	logic [16:0]       rem_dbl;
	logic              q_bit;
	logic [16:0]       v_full;
	logic [15:0]       sq_op;
	logic [15:0]       mul_a;
	logic [15:0]       mul_b;
	logic              ascending;
	logic [7:0]        span;
	logic [32:0]       out_diff;
	logic [32:0]       in_out_hi;
	logic [15:0]       ease_val;
	logic [24:0]       drop_sum;
	logic [7:0]        alpha_calc;

	assign sum          = SUM_W'(elapsed_q) + SUM_W'(tick_time);
	assign elapsed_wide = WIDE_W'(elapsed_q);
	assign dur_wide     = WIDE_W'(fade_duration_q);
	assign stat.fade_over = done_q || (elapsed_wide >= dur_wide);

	// restoring divider step; remainder stays below the duration
	assign rem_dbl = {rem_q, 1'b0};
	assign q_bit   = (rem_dbl >= {1'b0, fade_duration_q});

	// ease-in-out upper half works on v = 1 - u, at most one half
	assign v_full = 17'h10000 - {1'b0, quo_q};
	assign sq_op  = (curve_mode_q == CURVE_IN_OUT && quo_q[15]) ? v_full[15:0] : quo_q;

	assign ascending = (end_level_q >= start_level_q);
	assign span      = ascending ? (end_level_q - start_level_q) : (start_level_q - end_level_q);

	always_comb begin
		if (cmd.scale) begin
			mul_a = ease_q;
			mul_b = {8'd0, span};
		end else begin
			mul_a = sq_op;
			mul_b = sq_op;
		end
	end

	// u*(2 - u) = 2u - u^2; 1 - 2v^2 for the upper half of ease-in-out
	assign out_diff  = {quo_q, 17'd0} - {1'b0, prod_q};
	assign in_out_hi = 33'h1_0000_0000 - {prod_q, 1'b0};

	always_comb begin
		unique case (curve_mode_q)
			CURVE_LINEAR:   ease_val = quo_q;
			CURVE_EASE_IN:  ease_val = prod_q[31:16];
			CURVE_EASE_OUT: ease_val = out_diff[31:16];
			CURVE_IN_OUT:   ease_val = quo_q[15] ? in_out_hi[31:16] : prod_q[30:15];
			default:        ease_val = quo_q;
		endcase
	end

	// descending fade rounds the drop up so the floor goes toward minus infinity
	assign drop_sum = {1'b0, prod_q[23:0]} + 25'd65535;

	always_comb begin
		if (done_q)
			alpha_calc = end_level_q;
		else if (ascending)
			alpha_calc = start_level_q + prod_q[23:16];
		else
			alpha_calc = start_level_q - drop_sum[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q    <= CURVE_LINEAR;
			start_level_q   <= 8'd0;
			end_level_q     <= 8'd255;
			fade_duration_q <= 16'd1000;
			elapsed_q       <= '0;
			done_q          <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_CURVE_MODE:    curve_mode_q    <= cfg_data[1:0];
					CFG_START_LEVEL:   start_level_q   <= cfg_data[7:0];
					CFG_END_LEVEL:     end_level_q     <= cfg_data[7:0];
					CFG_FADE_DURATION: fade_duration_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (sum > SUM_W'(TIME_MAX))
					elapsed_q <= TIME_MAX;
				else
					elapsed_q <= sum[TIME_BITS-1:0];
			end
			if (cmd.check && stat.fade_over)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			rem_q <= elapsed_wide[15:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? 16'(rem_dbl - {1'b0, fade_duration_q}) : rem_dbl[15:0];
			quo_q <= {quo_q[14:0], q_bit};
		end
		if (cmd.ease_mul || cmd.scale)
			prod_q <= mul_a * mul_b;
		if (cmd.ease)
			ease_q <= ease_val;
		if (cmd.result) begin
			alpha_q     <= alpha_calc;
			fade_done_q <= done_q;
		end
	end

	assign alpha_out = alpha_q;
	assign fade_done = fade_done_q;

endmodule

[rtl/eased_alpha_fade.sv]
// Top level of the eased alpha fade block.
// Joins eaf_ctrl and eaf_datapath; depends on eaf_pkg.
//
// Usage:
//  - Config port: cfg_write, cfg_index, cfg_data. Index 0 curve mode,
//    1 start level, 2 end level, 3 fade duration. Write only while idle.
//  - Tick channel: tick_valid / tick_stall carrying tick_time. A transfer
//    happens on a rising edge with valid high and stall low.
//  - Result channel: result_valid / result_stall carrying alpha_out and
//    fade_done; one result per tick.
//  - Sequence: from tick transfer to result valid the controller runs
//    check, 16 divider steps, square, ease, scale and load while the fade
//    runs, or check and load once the fade is over. A new tick is taken
//    only after the load, back in idle. Most of the sequence is the
//    16-step restoring divider for elapsed/duration.
//  - The result sits in an output register, so the next tick is accepted
//    while the receiver stalls; if the previous result is still held when a
//    new one is ready, the controller waits in its load state.
//  - Reset clears elapsed time and the done flag, drops result_valid and
//    restores register defaults (linear, 0, 255, 1000). Config writes do
//    not touch elapsed time or done.
module eased_alpha_fade import eaf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        tick_valid,
	output logic        tick_stall,
	input  logic [15:0] tick_time,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  alpha_out,
	output logic        fade_done
);

	eaf_cmd_t  cmd;
	eaf_stat_t stat;

	// sequencing and output valid
	eaf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// registers, divider, multiplier, output payload
	eaf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick_time (tick_time),
		.cmd       (cmd),
		.stat      (stat),
		.alpha_out (alpha_out),
		.fade_done (fade_done)
	);

endmodule
